// File: hw/rtl/ltok_pkg.sv
package ltok_pkg;

  localparam int unsigned MaxRes = 5;
  localparam int unsigned CntW   = 3;

  localparam logic [7:0] ChUnder = 8'h5F;  // '_'
  localparam logic [7:0] ChDot   = 8'h2E;  // '.'
  localparam logic [7:0] ChQuote = 8'h22;  // '"'
  localparam logic [7:0] ChEq    = 8'h3D;  // '='
  localparam logic [7:0] ChBang  = 8'h21;  // '!'
  localparam logic [7:0] ChLt    = 8'h3C;  // '<'
  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_LINE = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_WORD = 4'b0010,
    MODE_STR  = 4'b0100,
    MODE_HOLD = 4'b1000
  } mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] token_char;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [CntW-1:0]   cnt;
  } bundle_t;

  function automatic res_t mk_res(kind_e kind, logic [7:0] c);
    res_t r;
    r.kind       = kind;
    r.token_char = (kind == KIND_CHAR) ? c : 8'h00;
    return r;
  endfunction

endpackage

// File: hw/rtl/ltok_if.sv
interface ltok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_last;

  modport source (output valid, output ch, output line_last, input ready);
  modport sink   (input valid, input ch, input line_last, output ready);
endinterface

interface ltok_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] token_char;
  logic       run_last;

  modport source (output valid, output kind, output token_char, output run_last, input ready);
  modport sink   (input valid, input kind, input token_char, input run_last, output ready);
endinterface

// File: hw/rtl/ltok_lexer.sv
// Per-byte lexer: next state and the burst of results for one byte.
module ltok_lexer import ltok_pkg::*; (
  input  logic [7:0] ch_i,
  input  logic       last_i,
  input  mode_e      mode_i,
  input  logic [7:0] pend_i,
  output bundle_t    bundle_o,
  output mode_e      mode_o,
  output logic [7:0] pend_o
);

  logic            is_space;
  logic            is_word;
  logic            is_pair;

  assign is_space = (ch_i == ChSpace) || (ch_i inside {[8'd9:8'd13]});
  assign is_word  = (ch_i inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
                    (ch_i == ChDot) || (ch_i == ChUnder);
  assign is_pair  = (ch_i == ChBang) || (ch_i == ChEq) || (ch_i == ChLt) || (ch_i == ChGt);

  always_comb begin
    logic [CntW-1:0] n;
    logic            used;
    mode_e           m;
    logic [7:0]      p;
    bundle_o = '0;
    n        = '0;
    used     = 1'b0;
    m        = mode_i;
    p        = pend_i;

    // held operator resolves against this byte
    if (m == MODE_HOLD) begin
      bundle_o.res[n] = mk_res(KIND_CHAR, p);
      n = n + 1'b1;
      if (ch_i == ChEq) begin
        bundle_o.res[n] = mk_res(KIND_CHAR, ch_i);
        n = n + 1'b1;
        used = 1'b1;
      end
      bundle_o.res[n] = mk_res(KIND_END, 8'h00);
      n = n + 1'b1;
      m = MODE_IDLE;
      p = 8'h00;
    end

    if (!used) begin
      if (m == MODE_STR) begin
        bundle_o.res[n] = mk_res(KIND_CHAR, ch_i);
        n = n + 1'b1;
        if (ch_i == ChQuote) begin
          bundle_o.res[n] = mk_res(KIND_END, 8'h00);
          n = n + 1'b1;
          m = MODE_IDLE;
        end
      end else if (is_space) begin
        if (m == MODE_WORD) begin
          bundle_o.res[n] = mk_res(KIND_END, 8'h00);
          n = n + 1'b1;
        end
        m = MODE_IDLE;
      end else if (is_word) begin
        bundle_o.res[n] = mk_res(KIND_CHAR, ch_i);
        n = n + 1'b1;
        m = MODE_WORD;
      end else if (ch_i == ChQuote) begin
        if (m == MODE_WORD) begin
          bundle_o.res[n] = mk_res(KIND_END, 8'h00);
          n = n + 1'b1;
        end
        bundle_o.res[n] = mk_res(KIND_CHAR, ch_i);
        n = n + 1'b1;
        m = MODE_STR;
      end else begin
        if (m == MODE_WORD) begin
          bundle_o.res[n] = mk_res(KIND_END, 8'h00);
          n = n + 1'b1;
        end
        if (is_pair && !last_i) begin
          p = ch_i;
          m = MODE_HOLD;
        end else begin
          bundle_o.res[n] = mk_res(KIND_CHAR, ch_i);
          n = n + 1'b1;
          bundle_o.res[n] = mk_res(KIND_END, 8'h00);
          n = n + 1'b1;
          m = MODE_IDLE;
        end
      end
    end

    // line end closes whatever is open
    if (last_i) begin
      if ((m == MODE_WORD) || (m == MODE_STR)) begin
        bundle_o.res[n] = mk_res(KIND_END, 8'h00);
        n = n + 1'b1;
      end
      bundle_o.res[n] = mk_res(KIND_LINE, 8'h00);
      n = n + 1'b1;
      m = MODE_IDLE;
      p = 8'h00;
    end

    bundle_o.cnt = n;
    mode_o       = m;
    pend_o       = p;
  end

endmodule

// File: hw/rtl/line_tokenizer_unit.sv
// A byte accepted into the input register moves through the lexer into the result
//   register, which shows its first result, once the result register is free.
// Throughput: one byte per cycle while the output is ready and no byte gives more
//   than one result; a byte's results (up to five) all leave before the next byte's.
// The result register drains while the input register fills, so both sides overlap.
// Reset (rst_ni low, asynchronous): pipeline empties, lexer returns between tokens.
module line_tokenizer_unit import ltok_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  ltok_in_if.sink     in_i,
  ltok_out_if.source  out_o
);

  // Input register: one byte waiting for the lexer.
  logic            s1_valid_q;
  logic [7:0]      s1_ch_q;
  logic            s1_last_q;

  // Result register: the burst of one byte, walked word by word.
  logic            b_valid_q;
  bundle_t         b_q;
  logic [CntW-1:0] idx_q;

  // Lexer state carried across bytes of a line.
  mode_e           mode_q, mode_d;
  logic [7:0]      pend_q, pend_d;

  bundle_t         bundle_d;
  res_t            cur;
  logic            run_last;
  logic            take;
  logic            pop_last;
  logic            adv;

  ltok_lexer u_lexer (
    .ch_i     (s1_ch_q),
    .last_i   (s1_last_q),
    .mode_i   (mode_q),
    .pend_i   (pend_q),
    .bundle_o (bundle_d),
    .mode_o   (mode_d),
    .pend_o   (pend_d)
  );

  assign cur      = b_q.res[idx_q];
  assign run_last = (idx_q == (b_q.cnt - 1'b1));
  assign take     = b_valid_q && out_o.ready;
  assign pop_last = take && run_last;
  // lexer consumes the held byte once the result register is free or freeing
  assign adv      = s1_valid_q && (!b_valid_q || pop_last);

  assign in_i.ready       = !s1_valid_q || adv;
  assign out_o.valid      = b_valid_q;
  assign out_o.kind       = cur.kind;
  assign out_o.token_char = cur.token_char;
  assign out_o.run_last   = run_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q   <= in_i.ch;
      s1_last_q <= in_i.line_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      idx_q     <= '0;
      mode_q    <= MODE_IDLE;
      pend_q    <= 8'h00;
    end else if (adv) begin
      // quiet bytes (no results) leave the result register empty
      b_valid_q <= (bundle_d.cnt != '0);
      idx_q     <= '0;
      mode_q    <= mode_d;
      pend_q    <= pend_d;
    end else if (pop_last) begin
      b_valid_q <= 1'b0;
      idx_q     <= '0;
    end else if (take) begin
      idx_q     <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_q <= bundle_d;
    end
  end

endmodule

// File: hw/rtl/ltok_checker.sv
module ltok_checker import ltok_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [7:0] out_token_char_i,
  input logic       out_run_last_i
);

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KIND_CHAR) |-> (out_token_char_i == 8'h00))
    else $error("token_char nonzero on a mark");

  a_line_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_LINE) |-> out_run_last_i)
    else $error("end of line not last of its run");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_kind_i <= KIND_LINE))
    else $error("illegal kind code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
      $stable(out_token_char_i) && $stable(out_run_last_i))
    else $error("stalled result changed");

endmodule

bind line_tokenizer_unit ltok_checker u_ltok_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_token_char_i (out_o.token_char),
  .out_run_last_i   (out_o.run_last)
);
